### rtl/map_text_tokenizer_macros.svh
// Assertion macros shared by the map text tokenizer RTL.
`ifndef MAP_TEXT_TOKENIZER_MACROS_SVH
`define MAP_TEXT_TOKENIZER_MACROS_SVH

// Checked on every rising clk edge outside reset.
`define MTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising clk edge, reset included.
`define MTT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/map_tok_pkg.sv
// Types and constants of the map text tokenizer.
`default_nettype none

package map_tok_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int FIELD_BITS  = 32;

  typedef logic [OFFSET_BITS-1:0] offset_t;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_LAST = 2'd1,
    OP_EOF  = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    KIND_END      = 4'd0,
    KIND_LBRACE   = 4'd1,
    KIND_RBRACE   = 4'd2,
    KIND_LBRACKET = 4'd3,
    KIND_RBRACKET = 4'd4,
    KIND_LPAREN   = 4'd5,
    KIND_RPAREN   = 4'd6,
    KIND_NAME     = 4'd7,
    KIND_STRING   = 4'd8,
    KIND_NUMBER   = 4'd9
  } kind_t;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_MINUS   = 4'd1,
    MODE_SLASH   = 4'd2,
    MODE_COMMENT = 4'd3,
    MODE_NAME    = 4'd4,
    MODE_STRING  = 4'd5,
    MODE_ESCAPE  = 4'd6,
    MODE_INT     = 4'd7,
    MODE_FRAC    = 4'd8,
    MODE_EXP     = 4'd9,
    MODE_EXPDIG  = 4'd10
  } mode_t;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPER_E = 8'h45;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_LOWER_E = 8'h65;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam int MAX_TOKS = 3;

  typedef struct packed {
    kind_t                 kind;
    logic [FIELD_BITS-1:0] start;
    logic [FIELD_BITS-1:0] len;
    logic                  last;
  } tok_t;

  // Tokens produced by one input transaction, handed to the output queue.
  typedef struct packed {
    logic                   push;
    logic [1:0]             cnt;
    tok_t [MAX_TOKS-1:0]    toks;
  } tok_bundle_t;

endpackage

`default_nettype wire

### rtl/map_tok_scan.sv
// Input register, scanner state and per-byte token logic.
`default_nettype none

`include "map_text_tokenizer_macros.svh"

module map_tok_scan import map_tok_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_op_bits,
  input  wire logic [7:0]  in_byte_bits,
  input  wire logic        q_free,
  output tok_bundle_t      bundle
);

  logic       in_vld;
  logic [1:0] in_op;
  logic [7:0] in_byte;

  mode_t   mode, mode_next;
  offset_t tb, tb_next;
  offset_t bp, bp_next;

  logic       adv;
  logic       rescan;
  logic [1:0] n;
  tok_t [MAX_TOKS-1:0] toks;
  offset_t    pos;

  function automatic offset_t sat_inc(input offset_t v);
    return (v == '1) ? v : v + offset_t'(1);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic is_name_byte(input logic [7:0] b);
    return (b > CH_SPACE) && (b <= CH_DEL);
  endfunction

  function automatic tok_t mk_tok(input kind_t k, input offset_t s, input offset_t l);
    tok_t t;
    t.kind  = k;
    t.start = FIELD_BITS'(s);
    t.len   = FIELD_BITS'(l);
    t.last  = 1'b0;
    return t;
  endfunction

  always_comb begin
    mode_next = mode;
    tb_next   = tb;
    bp_next   = bp;
    n         = 2'd0;
    toks      = '0;
    rescan    = 1'b0;
    pos       = bp;

    if (in_op == OP_BYTE || in_op == OP_LAST) begin
      bp_next = sat_inc(bp);
      unique case (mode) inside
        MODE_COMMENT: begin
          if (in_byte == CH_LF || in_byte == CH_CR) mode_next = MODE_IDLE;
        end
        MODE_MINUS, MODE_SLASH, MODE_NAME: begin
          if (mode == MODE_MINUS && is_digit(in_byte)) begin
            mode_next = MODE_INT;
          end else if (mode == MODE_SLASH && in_byte == CH_SLASH) begin
            mode_next = MODE_COMMENT;
          end else if (is_name_byte(in_byte)) begin
            mode_next = MODE_NAME;
          end else begin
            toks[n] = mk_tok(KIND_NAME, tb, pos - tb);
            n = n + 2'd1;
            mode_next = MODE_IDLE;
          end
        end
        MODE_STRING: begin
          if (in_byte == CH_BSLASH) begin
            mode_next = MODE_ESCAPE;
          end else if (in_byte == CH_QUOTE) begin
            toks[n] = mk_tok(KIND_STRING, tb, pos - tb);
            n = n + 2'd1;
            mode_next = MODE_IDLE;
          end
        end
        MODE_ESCAPE: mode_next = MODE_STRING;
        MODE_INT, MODE_FRAC, MODE_EXP, MODE_EXPDIG: begin
          if (mode != MODE_EXP && is_digit(in_byte)) begin
            mode_next = mode;
          end else if (mode == MODE_EXP && (is_digit(in_byte) || in_byte == CH_MINUS
                                           || in_byte == CH_PLUS)) begin
            mode_next = MODE_EXPDIG;
          end else if (mode == MODE_INT && in_byte == CH_DOT) begin
            mode_next = MODE_FRAC;
          end else if ((mode == MODE_INT || mode == MODE_FRAC)
                       && (in_byte == CH_LOWER_E || in_byte == CH_UPPER_E)) begin
            mode_next = MODE_EXP;
          end else begin
            // number ends; the byte is scanned again from idle
            toks[n] = mk_tok(KIND_NUMBER, tb, pos - tb);
            n = n + 2'd1;
            mode_next = MODE_IDLE;
            rescan = 1'b1;
          end
        end
        default: begin
          mode_next = MODE_IDLE;
          rescan = 1'b1;
        end
      endcase

      if (rescan && is_name_byte(in_byte)) begin
        tb_next = pos;
        case (in_byte)
          CH_SLASH: mode_next = MODE_SLASH;
          CH_MINUS: mode_next = MODE_MINUS;
          CH_QUOTE: begin
            tb_next   = sat_inc(pos);
            mode_next = MODE_STRING;
          end
          CH_LBRACE: begin
            toks[n] = mk_tok(KIND_LBRACE, pos, offset_t'(1));
            n = n + 2'd1;
          end
          CH_RBRACE: begin
            toks[n] = mk_tok(KIND_RBRACE, pos, offset_t'(1));
            n = n + 2'd1;
          end
          CH_LBRACKET: begin
            toks[n] = mk_tok(KIND_LBRACKET, pos, offset_t'(1));
            n = n + 2'd1;
          end
          CH_RBRACKET: begin
            toks[n] = mk_tok(KIND_RBRACKET, pos, offset_t'(1));
            n = n + 2'd1;
          end
          CH_LPAREN: begin
            toks[n] = mk_tok(KIND_LPAREN, pos, offset_t'(1));
            n = n + 2'd1;
          end
          CH_RPAREN: begin
            toks[n] = mk_tok(KIND_RPAREN, pos, offset_t'(1));
            n = n + 2'd1;
          end
          default: mode_next = is_digit(in_byte) ? MODE_INT : MODE_NAME;
        endcase
      end
    end

    // end of file: flush the open token, then the end token
    if (in_op == OP_LAST || in_op == OP_EOF) begin
      unique case (mode_next) inside
        MODE_MINUS, MODE_SLASH, MODE_NAME: begin
          toks[n] = mk_tok(KIND_NAME, tb_next, bp_next - tb_next);
          n = n + 2'd1;
        end
        MODE_STRING, MODE_ESCAPE: begin
          toks[n] = mk_tok(KIND_STRING, tb_next, bp_next - tb_next);
          n = n + 2'd1;
        end
        MODE_INT, MODE_FRAC, MODE_EXP, MODE_EXPDIG: begin
          toks[n] = mk_tok(KIND_NUMBER, tb_next, bp_next - tb_next);
          n = n + 2'd1;
        end
        default: ;
      endcase
      toks[n] = mk_tok(KIND_END, bp_next, '0);
      n = n + 2'd1;
      mode_next = MODE_IDLE;
      tb_next   = '0;
      bp_next   = '0;
    end

    if (n != 2'd0) toks[n - 2'd1].last = 1'b1;
  end

  // Token-free transactions never wait on the output queue.
  assign adv      = in_vld && ((n == 2'd0) || q_free);
  assign in_ready = !in_vld || adv;

  assign bundle.push = adv && (n != 2'd0);
  assign bundle.cnt  = n;
  assign bundle.toks = toks;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
      mode   <= MODE_IDLE;
      tb     <= '0;
      bp     <= '0;
    end else begin
      if (in_valid && in_ready) begin
        in_vld <= 1'b1;
      end else if (adv) begin
        in_vld <= 1'b0;
      end
      if (adv) begin
        mode <= mode_next;
        tb   <= tb_next;
        bp   <= bp_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_op   <= in_op_bits;
      in_byte <= in_byte_bits;
    end
  end

  `MTT_ASSERT(a_eof_resets,
              adv && (in_op == OP_LAST || in_op == OP_EOF)
              |=> mode == MODE_IDLE && bp == '0 && tb == '0,
              "scanner not back to reset state after end of file")
  `MTT_ASSERT(a_eof_emits,
              adv && in_op == OP_EOF
              |-> bundle.push && bundle.toks[n - 2'd1].kind == KIND_END,
              "end of file without an end token")
  `MTT_ASSERT(a_begin_order, tb <= bp, "token start beyond byte count")

endmodule

`default_nettype wire

### rtl/map_tok_outq.sv
// Three-entry token queue that drives the result stream.
`default_nettype none

`include "map_text_tokenizer_macros.svh"

module map_tok_outq import map_tok_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire tok_bundle_t bundle,
  output logic             free,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,
  output logic [3:0]       m_tuser,
  output logic             m_tlast
);

  tok_t [MAX_TOKS-1:0] q;
  logic [1:0]          cnt;
  logic                pop;

  assign m_tvalid = (cnt != 2'd0);
  assign pop      = m_tvalid && m_tready;
  assign free     = (cnt == 2'd0) || ((cnt == 2'd1) && m_tready);

  assign m_tdata = {q[0].len, q[0].start};
  assign m_tuser = q[0].kind;
  assign m_tlast = q[0].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (bundle.push) begin
      cnt <= bundle.cnt;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (bundle.push) begin
      q <= bundle.toks;
    end else if (pop) begin
      q[0] <= q[1];
      q[1] <= q[2];
    end
  end

  `MTT_ASSERT(a_push_free, bundle.push |-> free, "tokens pushed into a busy queue")
  `MTT_ASSERT(a_last_empties,
              pop && m_tlast && !bundle.push |=> cnt == 2'd0,
              "queue not empty after last token of a run")
  `MTT_ASSERT(a_mid_run,
              m_tvalid && !m_tlast |-> cnt >= 2'd2,
              "run ends without a last token")

endmodule

`default_nettype wire

### rtl/map_text_tokenizer.sv
// Top level of the streaming map text tokenizer.
`default_nettype none

// Map text tokenizer. Bytes of a map file arrive one per input transaction
// (s_tuser opcode: byte, last byte of file, or end of file without a byte)
// and token records (kind, start offset, length) leave on the master side,
// m_tlast marking the final token caused by one input transaction. Each
// transaction causes zero to three tokens; an end token always closes a
// file and leaves the block ready for the next one. The block takes one
// byte per clock as long as each byte yields at most one token and the
// master side takes each token at once: a byte is held in an input
// register, its mode transition and tokens are worked out combinationally
// from that register, and the tokens wait in a three-entry output queue.
// The next token-producing byte waits until the queue is down to its last
// entry being taken; bytes that yield no token pass meanwhile. Offsets
// and the byte count saturate at all ones. An accepted byte passes through
// the input register, then the output queue, before its first token shows.
module map_text_tokenizer import map_tok_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
  input  wire logic [1:0]  s_tuser,   // [1:0] opcode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // [31:0] start_offset, [63:32] token_length
  output logic [3:0]       m_tuser,   // [3:0] token_kind
  output logic             m_tlast    // last_of_run
);

  tok_bundle_t bundle;
  logic        q_free;

  // Scanner: input register, mode/offset state, token generation.
  map_tok_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_op_bits   (s_tuser),
    .in_byte_bits (s_tdata),
    .q_free       (q_free),
    .bundle       (bundle)
  );

  // Output queue: one token transaction per cycle on the master side while m_tready is high.
  map_tok_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .bundle   (bundle),
    .free     (q_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire
